// File: src/nec_pkg.sv
// Shared types and constants for the NEC infrared frame decoder.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package nec_pkg;

  localparam int TIME_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int STATUS_W  = 2;
  localparam int FRAME_BITS_DEF = 32;
  localparam int Q_DEPTH   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_MARK_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_MARK_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_SPACE_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD = 3'd5;

  // Reset values of the configuration registers, in 8 us ticks.
  localparam logic [CFG_W-1:0] RST_LEAD_MARK_MIN = 16'd1072;
  localparam logic [CFG_W-1:0] RST_LEAD_MARK_MAX = 16'd1215;
  localparam logic [CFG_W-1:0] RST_BIT_MARK_MIN  = 16'd55;
  localparam logic [CFG_W-1:0] RST_BIT_MARK_MAX  = 16'd81;
  localparam logic [CFG_W-1:0] RST_BIT_SPACE_MAX = 16'd254;
  localparam logic [CFG_W-1:0] RST_ONE_THRESHOLD = 16'd140;

  // Leading space windows in 128 us units (space >> 4), all bounds exclusive
  // for the repeat window and inclusive for the frame start window.
  localparam logic [TIME_W-5:0] REP_LO   = 12'd16;
  localparam logic [TIME_W-5:0] REP_HI   = 12'd22;
  localparam logic [TIME_W-5:0] START_LO = 12'd32;
  localparam logic [TIME_W-5:0] START_HI = 12'd36;
  localparam logic [TIME_W-1:0] SPACE_MIN = 16'd55;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_FRAME  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REPEAT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERROR  = 2'd2;

  // Classification of one pulse, as handed from the front to the back.
  typedef struct packed {
    logic lead_ok;   // mark inside the leading window
    logic rep_sp;    // leading space means repeat
    logic start_sp;  // leading space means frame start
    logic mark_ok;   // mark inside the bit window
    logic space_ok;  // space inside the data bit window
    logic is_one;    // space decodes as a logical one
  } cls_t;

endpackage
`default_nettype wire

// File: src/nec_if.sv
// Handshake channels of the decoder: pulse words in, result words out.
// Depends on nec_pkg for field widths.
`default_nettype none
interface nec_in_if;
  logic                          valid;
  logic                          ready;
  logic [nec_pkg::TIME_W-1:0]    mark_time;
  logic [nec_pkg::TIME_W-1:0]    space_time;
  modport source(output valid, mark_time, space_time, input ready);
  modport sink(input valid, mark_time, space_time, output ready);
endinterface

interface nec_out_if;
  logic                          valid;
  logic                          ready;
  logic [nec_pkg::STATUS_W-1:0]  status;
  logic [15:0]                   address;
  logic [7:0]                    command;
  logic [7:0]                    command_inverse;
  modport source(output valid, status, address, command, command_inverse, input ready);
  modport sink(input valid, status, address, command, command_inverse, output ready);
endinterface
`default_nettype wire

// File: src/nec_ir_frame_decoder.sv
// NEC infrared frame decoder, top level.
//
// in_ch carries one measured pulse per word: mark_time and space_time in 8 us
// ticks. out_ch carries one result word: status (frame, repeat or timing
// error), address, command and command_inverse. Both channels use a
// valid/ready handshake; a word moves on a rising edge where both are high.
// cfg_we, cfg_index and cfg_data write the six timing registers, one per
// cycle; writes to indexes beyond the sixth are dropped.
//
// A pulse accepted at one edge is classified into a two-word queue; the
// sequencer consumes it from the queue head once the result register is free
// or draining and, if it ends a frame or fails, the result word is valid right
// after that edge. One pulse is taken per cycle while out_ch does not stall,
// limited by the single sequencer step. When out_ch stalls, the held result
// blocks the sequencer and in_ch.ready drops once the queue holds two words.
// Synchronous reset (rst_n low) restores the register defaults, empties the
// queue and the result register and returns the sequencer to its wait phase.
// Depends on nec_pkg, nec_if, nec_front, nec_queue and nec_back.
`default_nettype none
module nec_ir_frame_decoder #(
  parameter int FRAME_BITS = nec_pkg::FRAME_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [nec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nec_pkg::CFG_W-1:0]      cfg_data,
  nec_in_if.sink                              in_ch,
  nec_out_if.source                           out_ch
);

  logic          q_push, q_full, q_not_empty, q_pop;
  nec_pkg::cls_t q_entry, q_head;

  nec_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  nec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .pop        (q_pop),
    .head       (q_head)
  );

  nec_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire

// File: src/nec_front.sv
// Front end: configuration registers, input word acceptance and pulse classification.
// Depends on nec_pkg and nec_in_if.
`default_nettype none
module nec_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [nec_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [nec_pkg::CFG_W-1:0]      cfg_data,
  nec_in_if.sink                              in_ch,
  input  wire logic                           q_full,
  output logic                                q_push,
  output nec_pkg::cls_t                       q_entry
);

  logic [nec_pkg::CFG_W-1:0] lead_min_r, lead_max_r, bit_min_r, bit_max_r;
  logic [nec_pkg::CFG_W-1:0] space_max_r, one_thr_r;
  logic [nec_pkg::TIME_W-5:0] units;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_min_r  <= nec_pkg::RST_LEAD_MARK_MIN;
      lead_max_r  <= nec_pkg::RST_LEAD_MARK_MAX;
      bit_min_r   <= nec_pkg::RST_BIT_MARK_MIN;
      bit_max_r   <= nec_pkg::RST_BIT_MARK_MAX;
      space_max_r <= nec_pkg::RST_BIT_SPACE_MAX;
      one_thr_r   <= nec_pkg::RST_ONE_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        nec_pkg::REG_LEAD_MARK_MIN: lead_min_r  <= cfg_data;
        nec_pkg::REG_LEAD_MARK_MAX: lead_max_r  <= cfg_data;
        nec_pkg::REG_BIT_MARK_MIN:  bit_min_r   <= cfg_data;
        nec_pkg::REG_BIT_MARK_MAX:  bit_max_r   <= cfg_data;
        nec_pkg::REG_BIT_SPACE_MAX: space_max_r <= cfg_data;
        nec_pkg::REG_ONE_THRESHOLD: one_thr_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign units       = in_ch.space_time[nec_pkg::TIME_W-1:4];

  // Every window is evaluated here; the back end picks what its phase needs.
  always_comb begin
    q_entry.lead_ok  = (in_ch.mark_time >= lead_min_r) && (in_ch.mark_time <= lead_max_r);
    q_entry.rep_sp   = (units > nec_pkg::REP_LO) && (units < nec_pkg::REP_HI);
    q_entry.start_sp = (units >= nec_pkg::START_LO) && (units <= nec_pkg::START_HI);
    q_entry.mark_ok  = (in_ch.mark_time >= bit_min_r) && (in_ch.mark_time <= bit_max_r);
    q_entry.space_ok = (in_ch.space_time >= nec_pkg::SPACE_MIN) &&
                       (in_ch.space_time <= space_max_r);
    q_entry.is_one   = in_ch.space_time > one_thr_r;
  end

endmodule
`default_nettype wire

// File: src/nec_queue.sv
// Short queue of classified pulses between the front and the back end.
// Depends on nec_pkg.
`default_nettype none
module nec_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire nec_pkg::cls_t  push_entry,
  output logic                full,
  output logic                not_empty,
  input  wire logic           pop,
  output nec_pkg::cls_t       head
);

  localparam int PTR_W = $clog2(nec_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(nec_pkg::Q_DEPTH + 1);

  nec_pkg::cls_t     mem [nec_pkg::Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full      = count_r == CNT_W'(nec_pkg::Q_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(nec_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(nec_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/nec_back.sv
// Back end: NEC phase sequencer, bit shifter and registered result word.
// Depends on nec_pkg and nec_out_if.
`default_nettype none
module nec_back #(
  parameter int FRAME_BITS = nec_pkg::FRAME_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_not_empty,
  input  wire nec_pkg::cls_t q_head,
  output logic               q_pop,
  nec_out_if.source          out_ch
);

  localparam int CNT_W = $clog2(FRAME_BITS + 1);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_STOP = 2'd2;

  logic [1:0]       phase_r, phase_nxt;
  logic             rep_r, rep_nxt;
  logic [CNT_W-1:0] bits_r, bits_nxt;
  logic [31:0]      frame_r, frame_nxt;
  logic [5:0]       bits_ext;
  logic [1:0]       byte_sel;

  logic             emit;
  logic [nec_pkg::STATUS_W-1:0] emit_status;
  logic [31:0]      emit_frame;

  logic             out_valid_r;
  logic [nec_pkg::STATUS_W-1:0] status_r;
  logic [31:0]      result_r;

  // A new word can be taken whenever the result register is free or draining.
  assign q_pop    = q_not_empty && (!out_valid_r || out_ch.ready);
  assign bits_ext = 6'(bits_r);
  assign byte_sel = bits_ext[4:3];

  always_comb begin
    phase_nxt   = phase_r;
    rep_nxt     = rep_r;
    bits_nxt    = bits_r;
    frame_nxt   = frame_r;
    emit        = 1'b0;
    emit_status = nec_pkg::ST_ERROR;
    emit_frame  = '0;
    case (phase_r)
      PH_DATA: begin
        if (!q_head.mark_ok || !q_head.space_ok) begin
          emit      = 1'b1;
          phase_nxt = PH_WAIT;
          rep_nxt   = 1'b0;
          bits_nxt  = '0;
        end else begin
          // Bits enter at the top of the current byte, so each byte ends LSB first.
          for (int i = 0; i < 4; i++) begin
            if (byte_sel == 2'(i)) begin
              frame_nxt[i*8 +: 8] = {q_head.is_one, frame_r[i*8+1 +: 7]};
            end
          end
          bits_nxt = bits_r + 1'b1;
          if (bits_nxt == CNT_W'(FRAME_BITS)) begin
            phase_nxt = PH_STOP;
          end
        end
      end
      PH_STOP: begin
        emit      = 1'b1;
        phase_nxt = PH_WAIT;
        rep_nxt   = 1'b0;
        bits_nxt  = '0;
        if (q_head.mark_ok) begin
          emit_status = rep_r ? nec_pkg::ST_REPEAT : nec_pkg::ST_FRAME;
          emit_frame  = frame_r;
        end
      end
      default: begin
        // Wait phase; the unused code falls back here as well.
        phase_nxt = PH_WAIT;
        if (q_head.lead_ok) begin
          if (q_head.rep_sp) begin
            phase_nxt = PH_STOP;
            rep_nxt   = 1'b1;
          end else if (q_head.start_sp) begin
            phase_nxt = PH_DATA;
            rep_nxt   = 1'b0;
            bits_nxt  = '0;
            frame_nxt = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      rep_r   <= 1'b0;
      bits_r  <= '0;
      frame_r <= '0;
    end else if (q_pop) begin
      phase_r <= phase_nxt;
      rep_r   <= rep_nxt;
      bits_r  <= bits_nxt;
      frame_r <= frame_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      status_r <= emit_status;
      result_r <= emit_frame;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.address         = result_r[15:0];
  assign out_ch.command         = result_r[23:16];
  assign out_ch.command_inverse = result_r[31:24];

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == nec_pkg::ST_ERROR) |-> (result_r == '0))
    else $error("error word carries a nonzero payload");

  a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r <= CNT_W'(FRAME_BITS))
    else $error("bit counter ran past the frame length");

  a_stop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STOP) && !rep_r |-> (bits_r == CNT_W'(FRAME_BITS)))
    else $error("stop phase reached without a complete frame");

  a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !q_pop)
    else $error("word taken from the queue while the result register is blocked");

endmodule
`default_nettype wire

// File: sim/nec_ir_frame_decoder_test.sv
// Self-checking testbench for the NEC infrared frame decoder.
// Depends on nec_pkg, the nec_in_if / nec_out_if channels and the decoder RTL.
`timescale 1ns / 1ps
module nec_ir_frame_decoder_test;

  localparam int NUM_BITS = nec_pkg::FRAME_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  // Unused register slots; writes to them must not disturb anything.
  localparam logic [nec_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [nec_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Leading space ranges in ticks: units 17..21 mean repeat, 32..36 frame start.
  localparam int REP_SPACE_LO   = (int'(nec_pkg::REP_LO) + 1) << 4;
  localparam int REP_SPACE_HI   = (int'(nec_pkg::REP_HI) << 4) - 1;
  localparam int START_SPACE_LO = int'(nec_pkg::START_LO) << 4;
  localparam int START_SPACE_HI = (int'(nec_pkg::START_HI) << 4) + 15;

  typedef enum logic [1:0] {PH_WAIT, PH_DATA, PH_STOP} dec_phase_t;

  typedef struct packed {
    logic [nec_pkg::STATUS_W-1:0] status;
    logic [15:0]                  address;
    logic [7:0]                   command;
    logic [7:0]                   command_inverse;
  } nec_result_t;

  class nec_frame_scoreboard;
    logic [nec_pkg::CFG_W-1:0] timing [6];
    dec_phase_t       phase;
    bit               repeat_pending;
    logic [5:0]       bits_taken;
    logic [31:0]      frame_shift;
    nec_result_t      expected_q [$];
    int               mismatches;

    function new();
      timing[nec_pkg::REG_LEAD_MARK_MIN] = nec_pkg::RST_LEAD_MARK_MIN;
      timing[nec_pkg::REG_LEAD_MARK_MAX] = nec_pkg::RST_LEAD_MARK_MAX;
      timing[nec_pkg::REG_BIT_MARK_MIN]  = nec_pkg::RST_BIT_MARK_MIN;
      timing[nec_pkg::REG_BIT_MARK_MAX]  = nec_pkg::RST_BIT_MARK_MAX;
      timing[nec_pkg::REG_BIT_SPACE_MAX] = nec_pkg::RST_BIT_SPACE_MAX;
      timing[nec_pkg::REG_ONE_THRESHOLD] = nec_pkg::RST_ONE_THRESHOLD;
      phase = PH_WAIT;
      repeat_pending = 1'b0;
      bits_taken = '0;
      frame_shift = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [nec_pkg::CFG_IDX_W-1:0] idx,
                            logic [nec_pkg::CFG_W-1:0] value);
      case (idx)
        nec_pkg::REG_LEAD_MARK_MIN, nec_pkg::REG_LEAD_MARK_MAX,
        nec_pkg::REG_BIT_MARK_MIN, nec_pkg::REG_BIT_MARK_MAX,
        nec_pkg::REG_BIT_SPACE_MAX, nec_pkg::REG_ONE_THRESHOLD: timing[idx] = value;
        default: ;
      endcase
    endfunction

    function void push_result(logic [nec_pkg::STATUS_W-1:0] status, logic [31:0] frame);
      nec_result_t r;
      r.status = status;
      r.address = frame[15:0];
      r.command = frame[23:16];
      r.command_inverse = frame[31:24];
      expected_q.push_back(r);
    endfunction

    function void abort_frame();
      phase = PH_WAIT;
      repeat_pending = 1'b0;
      bits_taken = '0;
      push_result(nec_pkg::ST_ERROR, '0);
    endfunction

    function void note_pulse(logic [nec_pkg::TIME_W-1:0] mark,
                             logic [nec_pkg::TIME_W-1:0] space);
      logic        mark_in_bit;
      logic [11:0] units;
      logic [7:0]  byte_val;
      int          sh;
      mark_in_bit = mark >= timing[nec_pkg::REG_BIT_MARK_MIN] &&
                    mark <= timing[nec_pkg::REG_BIT_MARK_MAX];
      case (phase)
        PH_DATA: begin
          if (!mark_in_bit || space < nec_pkg::SPACE_MIN ||
              space > timing[nec_pkg::REG_BIT_SPACE_MAX]) begin
            abort_frame();
          end else begin
            // Each byte fills from its top bit down, so bits land LSB first.
            sh = int'(bits_taken[4:3]) * 8;
            byte_val = frame_shift[sh +: 8] >> 1;
            if (space > timing[nec_pkg::REG_ONE_THRESHOLD]) byte_val[7] = 1'b1;
            frame_shift[sh +: 8] = byte_val;
            bits_taken = bits_taken + 6'd1;
            if (bits_taken >= NUM_BITS) phase = PH_STOP;
          end
        end
        PH_STOP: begin
          if (!mark_in_bit) begin
            abort_frame();
          end else begin
            push_result(repeat_pending ? nec_pkg::ST_REPEAT : nec_pkg::ST_FRAME,
                        frame_shift);
            phase = PH_WAIT;
            repeat_pending = 1'b0;
            bits_taken = '0;
          end
        end
        default: begin
          phase = PH_WAIT;
          units = space[15:4];
          if (mark >= timing[nec_pkg::REG_LEAD_MARK_MIN] &&
              mark <= timing[nec_pkg::REG_LEAD_MARK_MAX]) begin
            if (units > nec_pkg::REP_LO && units < nec_pkg::REP_HI) begin
              phase = PH_STOP;
              repeat_pending = 1'b1;
            end else if (units >= nec_pkg::START_LO && units <= nec_pkg::START_HI) begin
              phase = PH_DATA;
              repeat_pending = 1'b0;
              bits_taken = '0;
              frame_shift = '0;
            end
          end
        end
      endcase
    endfunction

    function void check_result(nec_result_t got);
      nec_result_t want;
      if (expected_q.size() == 0) begin
        $error("result word with nothing pending: status %0d address %h", got.status,
               got.address);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.address !== want.address) begin
        $error("address expected %h, got %h", want.address, got.address);
        mismatches++;
      end
      if (got.command !== want.command) begin
        $error("command expected %h, got %h", want.command, got.command);
        mismatches++;
      end
      if (got.command_inverse !== want.command_inverse) begin
        $error("command_inverse expected %h, got %h", want.command_inverse,
               got.command_inverse);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [nec_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [nec_pkg::CFG_W-1:0]     cfg_data;
  int                            send_idle_pct;
  int                            recv_idle_pct;
  int                            pulses_sent;
  int                            idle_cycles;

  nec_frame_scoreboard sb = new();

  nec_in_if  in_if ();
  nec_out_if out_if ();

  nec_ir_frame_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Results are checked before the same edge's input word is noted, so a
  // result can never be matched against a pulse that was not yet taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        sb.check_result('{out_if.status, out_if.address, out_if.command,
                          out_if.command_inverse});
      end
      if (in_if.valid && in_if.ready) sb.note_pulse(in_if.mark_time, in_if.space_time);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("nec_ir_frame_decoder verification failed");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pick(int lo, int hi);
    int r;
    r = $urandom_range(9);
    if (lo > hi) return 16'($urandom);
    if (r == 0) return 16'(lo);
    if (r == 1) return 16'(hi);
    return 16'($urandom_range(hi, lo));
  endfunction

  task automatic send_pulse(input logic [15:0] mark, input logic [15:0] space);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mark_time <= mark;
    in_if.space_time <= space;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pulses_sent++;
  endtask

  task automatic write_reg(input logic [nec_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nec_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic apply_config(input logic [15:0] lead_min, input logic [15:0] lead_max,
                              input logic [15:0] mark_min, input logic [15:0] mark_max,
                              input logic [15:0] space_max, input logic [15:0] one_thr);
    write_reg(nec_pkg::REG_LEAD_MARK_MIN, lead_min);
    write_reg(nec_pkg::REG_LEAD_MARK_MAX, lead_max);
    write_reg(nec_pkg::REG_BIT_MARK_MIN, mark_min);
    write_reg(nec_pkg::REG_BIT_MARK_MAX, mark_max);
    write_reg(nec_pkg::REG_BIT_SPACE_MAX, space_max);
    write_reg(nec_pkg::REG_ONE_THRESHOLD, one_thr);
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(REG_SPARE_HI, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Pulses that end in wait give no result, so an extra idle wait lets the
  // decoder finish them before anything is reconfigured. The first edge lets
  // the monitor note the last accepted word before the queue is examined.
  task automatic drain_pipeline();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One noise word, a repeat code or a whole frame, timed from the current
  // registers; now and then a word is replaced by noise and the rest dropped.
  task automatic send_sequence();
    int          kind, n, lmin, lmax, bmin, bmax, smax, thr;
    bit          one_bit, is_repeat;
    logic [15:0] m, s;
    lmin = sb.timing[nec_pkg::REG_LEAD_MARK_MIN];
    lmax = sb.timing[nec_pkg::REG_LEAD_MARK_MAX];
    bmin = sb.timing[nec_pkg::REG_BIT_MARK_MIN];
    bmax = sb.timing[nec_pkg::REG_BIT_MARK_MAX];
    smax = sb.timing[nec_pkg::REG_BIT_SPACE_MAX];
    thr  = sb.timing[nec_pkg::REG_ONE_THRESHOLD];
    kind = $urandom_range(99);
    if (kind < 15) begin
      send_pulse(16'($urandom), 16'($urandom));
      return;
    end
    is_repeat = kind < 35;
    n = is_repeat ? 2 : NUM_BITS + 2;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 2) begin
        send_pulse(16'($urandom), 16'($urandom));
        return;
      end
      if (k == 0) begin
        m = pick(lmin, lmax);
        s = is_repeat ? pick(REP_SPACE_LO, REP_SPACE_HI) : pick(START_SPACE_LO, START_SPACE_HI);
      end else if (k == n - 1) begin
        m = pick(bmin, bmax);
        s = 16'($urandom);
      end else begin
        one_bit = $urandom_range(1);
        if (thr + 1 > smax) one_bit = 1'b0;
        else if (thr < int'(nec_pkg::SPACE_MIN)) one_bit = 1'b1;
        m = pick(bmin, bmax);
        s = one_bit ? pick(thr + 1, smax) :
                      pick(int'(nec_pkg::SPACE_MIN), (thr < smax) ? thr : smax);
      end
      send_pulse(m, s);
    end
  endtask

  initial begin
    int target, lmin_r, bmin_r, smax_r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.mark_time = '0;
    in_if.space_time = '0;
    send_idle_pct = 19;
    recv_idle_pct = 88;
    pulses_sent = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pulses at the reset timing.
    send_pulse(16'd0, 16'd0);
    send_pulse(16'hFFFF, 16'hFFFF);
    send_pulse(16'd1071, 16'd512);
    send_pulse(16'd1216, 16'd512);
    send_pulse(16'd1072, 16'd271);
    send_pulse(16'd1215, 16'd352);
    // A repeat before any frame carries an all-zero frame.
    send_pulse(16'd1072, 16'd272);
    send_pulse(16'd55, 16'hFFFF);
    send_pulse(16'd1215, 16'd351);
    send_pulse(16'd54, 16'd0);
    send_pulse(16'd1100, 16'd512);
    send_pulse(16'd81, 16'd55);
    send_pulse(16'd55, 16'd254);
    send_pulse(16'd60, 16'd141);
    send_pulse(16'd60, 16'd140);
    send_pulse(16'd60, 16'd54);
    send_pulse(16'd1100, 16'd591);
    send_pulse(16'd82, 16'd200);
    send_pulse(16'd1100, 16'd592);
    send_pulse(16'd1100, 16'd511);
    send_pulse(16'd1100, 16'd512);
    send_pulse(16'd70, 16'd255);
    send_pulse(16'd1100, 16'd300);
    send_pulse(16'd82, 16'd0);
    send_pulse(16'd1100, 16'd544);
    send_pulse(16'd0, 16'hFFFF);

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      drain_pipeline();
      case (p)
        0: apply_config(nec_pkg::RST_LEAD_MARK_MIN, nec_pkg::RST_LEAD_MARK_MAX,
                        nec_pkg::RST_BIT_MARK_MIN, nec_pkg::RST_BIT_MARK_MAX,
                        nec_pkg::RST_BIT_SPACE_MAX, nec_pkg::RST_ONE_THRESHOLD);
        1: apply_config(16'd500, 16'd700, 16'd20, 16'd40, 16'd200, 16'd100);
        2: apply_config(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        3: begin
          lmin_r = $urandom_range(1200, 900);
          bmin_r = $urandom_range(60, 10);
          smax_r = $urandom_range(400, 150);
          apply_config(16'(lmin_r), 16'(lmin_r + $urandom_range(300)), 16'(bmin_r),
                       16'(bmin_r + $urandom_range(60)), 16'(smax_r),
                       16'($urandom_range(smax_r - 1, 56)));
        end
        // Inverted bit and space windows: every data or stop word must fail.
        4: apply_config(nec_pkg::RST_LEAD_MARK_MIN, nec_pkg::RST_LEAD_MARK_MAX, 16'hFFFF,
                        16'd0, 16'd0, 16'hFFFF);
        default: apply_config(16'd1100, 16'd1100, 16'd70, 16'd70, 16'd200, 16'd199);
      endcase
      target = pulses_sent + ((p == 4) ? 50 : 150);
      while (pulses_sent < target) send_sequence();
    end

    drain_pipeline();
    if (sb.mismatches == 0) begin
      $display("nec_ir_frame_decoder verification clean");
    end else begin
      $display("nec_ir_frame_decoder verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/nec_pkg.sv
src/nec_if.sv
src/nec_front.sv
src/nec_queue.sv
src/nec_back.sv
src/nec_ir_frame_decoder.sv
sim/nec_ir_frame_decoder_test.sv
